// ----- src/sct_pkg.sv -----
package sct_pkg;

    localparam int SIG_W   = 32;
    localparam int ACC_W   = 48;
    localparam int GAIN_W  = 17;
    localparam int GND_W   = 31;
    localparam int OPND_W  = 34;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int PC_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_TURNS_RATIO       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURNS_RATIO_RECIP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATOR_INDUCTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IND_SUM_RECIP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LEVEL       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND_LEVEL      = 3'd6;

    typedef struct packed {
        logic                    switch_closed;
        logic                    check_enable;
        logic signed [SIG_W-1:0] flux_x;
        logic signed [SIG_W-1:0] flux_y;
        logic signed [SIG_W-1:0] rotor_cur_x;
        logic signed [SIG_W-1:0] rotor_cur_y;
        logic signed [SIG_W-1:0] stator_meas_x;
        logic signed [SIG_W-1:0] stator_meas_y;
        logic                    voltage_match_ok;
        logic [GND_W-1:0]        ground_current;
    } t_in;

    typedef struct packed {
        logic signed [SIG_W-1:0] stator_calc_x;
        logic signed [SIG_W-1:0] stator_calc_y;
        logic [ACC_W-1:0]        error_filtered;
        logic                    ct_fault;
        logic                    ground_fault;
    } t_out;

    typedef struct packed {
        logic signed [SIG_W-1:0] turns_ratio;
        logic signed [SIG_W-1:0] turns_ratio_recip;
        logic signed [SIG_W-1:0] stator_inductance;
        logic signed [SIG_W-1:0] inductance_sum_recip;
        logic [GAIN_W-1:0]       filter_gain;
        logic [ACC_W-1:0]        error_level;
        logic [GND_W-1:0]        ground_level;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        turns_ratio:          32'sd65536,
        turns_ratio_recip:    32'sd65536,
        stator_inductance:    32'sd0,
        inductance_sum_recip: 32'sd65536,
        filter_gain:          17'd0,
        error_level:          48'hFFFF_FFFF_FFFF,
        ground_level:         31'h7FFF_FFFF
    };

    // Sequencing of one microinstruction
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JIDLE,
        SEQ_DONE
    } t_seq;

    // Multiplier operand A
    typedef enum logic [2:0] {
        A_FX, A_FY, A_LS, A_T0, A_T1, A_E, A_DLO, A_DHI
    } t_asel;

    // Multiplier operand B
    typedef enum logic [2:0] {
        B_RATIO, B_RX, B_RY, B_SR, B_RR, B_E, B_G
    } t_bsel;

    // Product writeback
    typedef enum logic [3:0] {
        WB_NONE, WB_T0_RND, WB_T0_ADD, WB_T1_RND, WB_T1_ADD, WB_T0_RX, WB_T1_RY,
        WB_CX, WB_CY, WB_S_SET, WB_S_ADD, WB_F_LO, WB_F_HI
    } t_wb;

    // Side ALU
    typedef enum logic [2:0] {
        ALU_NONE, ALU_EX, ALU_EY, ALU_DIFF, ALU_ACC, ALU_CLEAR
    } t_alu;

    typedef struct packed {
        t_seq            seq;
        logic [PC_W-1:0] target;
        logic            mul_en;
        t_asel           asel;
        t_bsel           bsel;
        t_wb             wb;
        t_alu            alu;
    } t_ctl;

    localparam t_ctl CTL_NOP = '{
        seq: SEQ_NEXT, target: '0, mul_en: 1'b0, asel: A_FX, bsel: B_RATIO,
        wb: WB_NONE, alu: ALU_NONE
    };

    localparam logic [PC_W-1:0] PC_CLEAR = 5'd17;

    // Microprogram. Each multiply result lands in the product register and is
    // written back by the following step, so x and y axes are interleaved.
    function automatic t_ctl f_ucode(input logic [PC_W-1:0] pc);
        t_ctl c;
        c = CTL_NOP;
        unique case (pc)
            5'd0: begin
                c.mul_en = 1'b1; c.asel = A_FX; c.bsel = B_RATIO;
                c.seq = SEQ_JIDLE; c.target = PC_CLEAR;
            end
            5'd1: begin
                c.mul_en = 1'b1; c.asel = A_LS; c.bsel = B_RX; c.wb = WB_T0_RND;
            end
            5'd2: begin
                c.mul_en = 1'b1; c.asel = A_FY; c.bsel = B_RATIO; c.wb = WB_T0_ADD;
            end
            5'd3: begin
                c.mul_en = 1'b1; c.asel = A_LS; c.bsel = B_RY; c.wb = WB_T1_RND;
            end
            5'd4: begin
                c.mul_en = 1'b1; c.asel = A_T0; c.bsel = B_SR; c.wb = WB_T1_ADD;
            end
            5'd5: begin
                c.mul_en = 1'b1; c.asel = A_T1; c.bsel = B_SR; c.wb = WB_T0_RX;
            end
            5'd6: begin
                c.mul_en = 1'b1; c.asel = A_T0; c.bsel = B_RR; c.wb = WB_T1_RY;
            end
            5'd7: begin
                c.mul_en = 1'b1; c.asel = A_T1; c.bsel = B_RR; c.wb = WB_CX;
            end
            5'd8: begin
                c.wb = WB_CY; c.alu = ALU_EX;
            end
            5'd9: begin
                c.mul_en = 1'b1; c.asel = A_E; c.bsel = B_E; c.alu = ALU_EY;
            end
            5'd10: begin
                c.mul_en = 1'b1; c.asel = A_E; c.bsel = B_E; c.wb = WB_S_SET;
            end
            5'd11: begin
                c.wb = WB_S_ADD;
            end
            5'd12: begin
                c.alu = ALU_DIFF;
            end
            5'd13: begin
                c.mul_en = 1'b1; c.asel = A_DLO; c.bsel = B_G;
            end
            5'd14: begin
                c.mul_en = 1'b1; c.asel = A_DHI; c.bsel = B_G; c.wb = WB_F_LO;
            end
            5'd15: begin
                c.wb = WB_F_HI;
            end
            5'd16: begin
                c.alu = ALU_ACC; c.seq = SEQ_DONE;
            end
            5'd17: begin
                c.alu = ALU_CLEAR; c.seq = SEQ_DONE;
            end
            default: begin
                c.seq = SEQ_DONE;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- src/sct_seq.sv -----
module sct_seq
    import sct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_idle_item,
    input  logic i_out_free,
    output t_ctl o_ctl,
    output logic o_ready,
    output logic o_load
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_ctl            w_word;

    assign w_word  = f_ucode(r_pc);
    assign o_ctl   = (r_state == ST_RUN) ? w_word : CTL_NOP;
    assign o_ready = (r_state == ST_IDLE);
    assign o_load  = (r_state == ST_WAIT) && i_out_free;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_pc    = '0;
                end
            end
            ST_RUN: begin
                unique case (w_word.seq)
                    SEQ_NEXT:  n_pc = r_pc + 1'b1;
                    SEQ_JIDLE: n_pc = i_idle_item ? w_word.target : r_pc + 1'b1;
                    SEQ_DONE:  n_state = ST_WAIT;
                    default:   n_state = ST_WAIT;
                endcase
            end
            ST_WAIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

// ----- src/sct_datapath.sv -----
module sct_datapath
    import sct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_in                   i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctl                  i_ctl,
    output logic                  o_idle_item,
    output t_out                  o_result
);

    t_in  r_in;
    t_cfg r_cfg;

    logic signed [PROD_W-1:0] r_p;
    logic signed [SIG_W-1:0]  r_t0, r_t1, r_cx, r_cy;
    logic [SIG_W-1:0]         r_e;
    logic [ACC_W-1:0]         r_s, r_d, r_acc;
    logic                     r_up;
    logic [ACC_W+16:0]        r_f;

    logic signed [OPND_W-1:0] w_a, w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SIG_W-1:0]  w_rnd;
    logic [GAIN_W-1:0]        w_gain;
    logic [ACC_W:0]           w_ssum;
    logic signed [SIG_W:0]    w_ediff;
    logic [ACC_W-1:0]         w_inc;

    function automatic logic signed [SIG_W-1:0] f_sat33(input logic signed [SIG_W:0] v);
        logic signed [SIG_W-1:0] r;
        if (v[SIG_W] != v[SIG_W-1]) begin
            r = v[SIG_W] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
        end else begin
            r = v[SIG_W-1:0];
        end
        return r;
    endfunction

    // Round Q32.32 product to Q16.16 with half-up, then saturate
    function automatic logic signed [SIG_W-1:0] f_rnd(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        logic signed [SIG_W-1:0]  r;
        q = (p + 68'sd32768) >>> 16;
        if (q > 68'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (q < -68'sd2147483648) begin
            r = -32'sh8000_0000;
        end else begin
            r = q[SIG_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [SIG_W-1:0] f_abs33(input logic signed [SIG_W:0] v);
        logic [SIG_W:0] m;
        m = v[SIG_W] ? (~v + 1'b1) : v;
        return m[SIG_W-1:0];
    endfunction

    assign o_idle_item = !(r_in.switch_closed || r_in.check_enable);
    assign w_gain      = (r_cfg.filter_gain > GAIN_ONE) ? GAIN_ONE : r_cfg.filter_gain;

    always_comb begin
        case (i_ctl.asel)
            A_FX:    w_a = OPND_W'(r_in.flux_x);
            A_FY:    w_a = OPND_W'(r_in.flux_y);
            A_LS:    w_a = OPND_W'(r_cfg.stator_inductance);
            A_T0:    w_a = OPND_W'(r_t0);
            A_T1:    w_a = OPND_W'(r_t1);
            A_E:     w_a = {2'b00, r_e};
            A_DLO:   w_a = {2'b00, r_d[31:0]};
            A_DHI:   w_a = {18'd0, r_d[47:32]};
            default: w_a = '0;
        endcase
        case (i_ctl.bsel)
            B_RATIO: w_b = OPND_W'(r_cfg.turns_ratio);
            B_RX:    w_b = OPND_W'(r_in.rotor_cur_x);
            B_RY:    w_b = OPND_W'(r_in.rotor_cur_y);
            B_SR:    w_b = OPND_W'(r_cfg.inductance_sum_recip);
            B_RR:    w_b = OPND_W'(r_cfg.turns_ratio_recip);
            B_E:     w_b = {2'b00, r_e};
            B_G:     w_b = {17'd0, w_gain};
            default: w_b = '0;
        endcase
    end

    assign w_prod  = PROD_W'(w_a) * PROD_W'(w_b);
    assign w_rnd   = f_rnd(r_p);
    assign w_ssum  = {1'b0, r_s} + {1'b0, r_p[63:16]};
    assign w_ediff = (i_ctl.alu == ALU_EX)
                   ? ({r_cx[SIG_W-1], r_cx} - {r_in.stator_meas_x[SIG_W-1], r_in.stator_meas_x})
                   : ({r_cy[SIG_W-1], r_cy} - {r_in.stator_meas_y[SIG_W-1], r_in.stator_meas_y});
    assign w_inc   = r_f[63:16];

    // Config and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
            r_acc <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TURNS_RATIO:       r_cfg.turns_ratio <= i_cfg_data[SIG_W-1:0];
                    CFG_TURNS_RATIO_RECIP: r_cfg.turns_ratio_recip <= i_cfg_data[SIG_W-1:0];
                    CFG_STATOR_INDUCTANCE: r_cfg.stator_inductance <= i_cfg_data[SIG_W-1:0];
                    CFG_IND_SUM_RECIP:     r_cfg.inductance_sum_recip <= i_cfg_data[SIG_W-1:0];
                    CFG_FILTER_GAIN:       r_cfg.filter_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_ERROR_LEVEL:       r_cfg.error_level <= i_cfg_data[ACC_W-1:0];
                    CFG_GROUND_LEVEL:      r_cfg.ground_level <= i_cfg_data[GND_W-1:0];
                    default: ;
                endcase
            end
            case (i_ctl.alu)
                ALU_ACC:   r_acc <= r_up ? (r_acc + w_inc) : (r_acc - w_inc);
                ALU_CLEAR: r_acc <= '0;
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_in <= i_in_data;
        end
        if (i_ctl.mul_en) begin
            r_p <= w_prod;
        end
        case (i_ctl.wb)
            WB_T0_RND: r_t0 <= w_rnd;
            WB_T0_ADD: r_t0 <= f_sat33({r_t0[SIG_W-1], r_t0} + {w_rnd[SIG_W-1], w_rnd});
            WB_T1_RND: r_t1 <= w_rnd;
            WB_T1_ADD: r_t1 <= f_sat33({r_t1[SIG_W-1], r_t1} + {w_rnd[SIG_W-1], w_rnd});
            WB_T0_RX:  r_t0 <= f_sat33({r_in.rotor_cur_x[SIG_W-1], r_in.rotor_cur_x}
                                       - {w_rnd[SIG_W-1], w_rnd});
            WB_T1_RY:  r_t1 <= f_sat33({r_in.rotor_cur_y[SIG_W-1], r_in.rotor_cur_y}
                                       - {w_rnd[SIG_W-1], w_rnd});
            WB_CX:     r_cx <= w_rnd;
            WB_CY:     r_cy <= w_rnd;
            WB_S_SET:  r_s  <= r_p[63:16];
            WB_S_ADD:  r_s  <= w_ssum[ACC_W] ? {ACC_W{1'b1}} : w_ssum[ACC_W-1:0];
            WB_F_LO:   r_f  <= {16'd0, r_p[48:0]};
            WB_F_HI:   r_f  <= r_f + {r_p[32:0], 32'd0};
            default: ;
        endcase
        case (i_ctl.alu)
            ALU_EX, ALU_EY: r_e <= f_abs33(w_ediff);
            ALU_DIFF: begin
                r_up <= (r_s >= r_acc);
                r_d  <= (r_s >= r_acc) ? (r_s - r_acc) : (r_acc - r_s);
            end
            ALU_CLEAR: begin
                r_cx <= '0;
                r_cy <= '0;
            end
            default: ;
        endcase
    end

    assign o_result.stator_calc_x  = r_cx;
    assign o_result.stator_calc_y  = r_cy;
    assign o_result.error_filtered = r_acc;
    assign o_result.ct_fault       = r_in.check_enable && r_in.voltage_match_ok
                                     && (r_acc > r_cfg.error_level);
    assign o_result.ground_fault   = r_in.check_enable
                                     && (r_in.ground_current > r_cfg.ground_level);

endmodule

// ----- src/stator_ct_consistency_check.sv -----
// Stator CT consistency check. Takes one sample request per control tick and
// returns one result request. With the stator switch closed or the check
// enabled, a 17-step microprogram drives a single shared 34x34 multiplier to
// form the magnetizing and computed stator currents on both axes, the summed
// squared error against the measured CT current and the low-pass filtered
// error; a sample that arrives with both flags low clears the filter and the
// computed currents in two steps. After accept the sequencer runs the program,
// then loads the result once the output slot is free, and the next sample is
// taken the cycle after the result is registered, while that result waits
// downstream. Faults are flagged only with check_enable high; the CT fault
// also needs voltage_match_ok. Configuration writes are taken in any cycle and
// belong between samples.
module stator_ct_consistency_check
    import sct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl w_ctl;
    t_out w_result;
    logic w_start, w_idle_item, w_out_free, w_load, w_seq_ready;

    logic r_out_valid;
    t_out r_out_data;

    // Accept a sample only while the sequencer is parked
    assign o_in_ready  = w_seq_ready;
    assign w_start     = i_in_valid && w_seq_ready;
    assign o_cfg_ready = 1'b1;

    // Output slot frees up when empty or drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    sct_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_idle_item (w_idle_item),
        .i_out_free  (w_out_free),
        .o_ctl       (w_ctl),
        .o_ready     (w_seq_ready),
        .o_load      (w_load)
    );

    sct_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .o_idle_item (w_idle_item),
        .o_result    (w_result)
    );

    // Hold the result until taken; load a new one when the program ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- src/sct_checker.sv -----
module sct_checker
    import sct_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // A sample keeps the block busy past the accept cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("sample taken on consecutive cycles");

    // No result can appear right after a sample is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared without processing");

    // A CT fault needs a filtered error above some level
    a_ct_needs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ct_fault |-> o_out_data.error_filtered != '0)
        else $error("CT fault with zero filtered error");

endmodule

bind stator_ct_consistency_check sct_checker u_sct_checker (.*);
